### rtl/core/hslhc_pkg.sv
// Package for the HTTP status line health check.
// Holds the parser state type, verdict and class codes, character constants
// and the status code classifier. Depends on nothing.
package hslhc_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CodeW  = 10;
  localparam int unsigned ClassW = 3;
  localparam int unsigned MaskW  = 5;
  localparam int unsigned DigitW = 2;

  localparam logic [MaskW-1:0] MaskReset = 5'b00011;

  typedef enum logic [3:0] {
    PS_START      = 4'd0,
    PS_H          = 4'd1,
    PS_HT         = 4'd2,
    PS_HTT        = 4'd3,
    PS_HTTP       = 4'd4,
    PS_MAJ_FIRST  = 4'd5,
    PS_MAJ        = 4'd6,
    PS_MIN_FIRST  = 4'd7,
    PS_MIN        = 4'd8,
    PS_CODE       = 4'd9,
    PS_AFTER_CODE = 4'd10,
    PS_TEXT       = 4'd11,
    PS_WANT_LF    = 4'd12,
    PS_WANT_CR    = 4'd13,
    PS_LAST_LF    = 4'd14
  } parse_state_e;

  typedef enum logic [1:0] {
    VERDICT_MORE  = 2'd0,
    VERDICT_ALIVE = 2'd1,
    VERDICT_ERROR = 2'd2,
    VERDICT_DEAD  = 2'd3
  } verdict_e;

  localparam logic [ClassW-1:0] CLASS_2XX   = 3'd0;
  localparam logic [ClassW-1:0] CLASS_3XX   = 3'd1;
  localparam logic [ClassW-1:0] CLASS_4XX   = 3'd2;
  localparam logic [ClassW-1:0] CLASS_5XX   = 3'd3;
  localparam logic [ClassW-1:0] CLASS_OTHER = 3'd4;

  localparam logic [ByteW-1:0] CH_H     = 8'h48;
  localparam logic [ByteW-1:0] CH_T     = 8'h54;
  localparam logic [ByteW-1:0] CH_P     = 8'h50;
  localparam logic [ByteW-1:0] CH_SLASH = 8'h2F;
  localparam logic [ByteW-1:0] CH_DOT   = 8'h2E;
  localparam logic [ByteW-1:0] CH_SPACE = 8'h20;
  localparam logic [ByteW-1:0] CH_CR    = 8'h0D;
  localparam logic [ByteW-1:0] CH_LF    = 8'h0A;
  localparam logic [ByteW-1:0] CH_ZERO  = 8'h30;
  localparam logic [ByteW-1:0] CH_ONE   = 8'h31;
  localparam logic [ByteW-1:0] CH_NINE  = 8'h39;

  // Result of one parser step, handed from the step logic to the top level.
  typedef struct packed {
    parse_state_e            next_state;
    logic [CodeW-1:0]        next_code;
    logic [DigitW-1:0]       next_digits;
    verdict_e                verdict;
    logic [CodeW-1:0]        status_code;
    logic [ClassW-1:0]       code_class;
    logic                    peer_error;
  } step_t;

  function automatic logic [ClassW-1:0] class_of(input logic [CodeW-1:0] code);
    logic [ClassW-1:0] cls;
    if (code >= 10'd200 && code < 10'd300) begin
      cls = CLASS_2XX;
    end else if (code >= 10'd300 && code < 10'd400) begin
      cls = CLASS_3XX;
    end else if (code >= 10'd400 && code < 10'd500) begin
      cls = CLASS_4XX;
    end else if (code >= 10'd500 && code < 10'd600) begin
      cls = CLASS_5XX;
    end else begin
      cls = CLASS_OTHER;
    end
    return cls;
  endfunction

endpackage

### rtl/core/hslhc_if.sv
// Handshake channels of the HTTP status line health check: the response
// byte channel and the result channel. Depends on hslhc_pkg.
interface hslhc_byte_if;
  logic                          valid;
  logic                          ready;
  logic [hslhc_pkg::ByteW-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hslhc_result_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    verdict;
  logic [hslhc_pkg::CodeW-1:0]   status_code;
  logic [hslhc_pkg::ClassW-1:0]  code_class;
  logic                          peer_error;

  modport source (output valid, output verdict, output status_code, output code_class,
                  output peer_error, input ready);
  modport sink   (input valid, input verdict, input status_code, input code_class,
                  input peer_error, output ready);
endinterface

### rtl/core/http_status_line_health_check.sv
// Top level of the HTTP status line health check.
// Depends on hslhc_pkg, hslhc_if (byte and result channels) and hslhc_step.

// The block takes one response byte per word on the rx_i channel and returns
// exactly one result word per byte on the res_o channel. Each result carries a
// verdict: need more bytes, alive, parse error, or class not alive; on the
// final byte of a complete status line it also carries the three-digit status
// code, its class and a peer error flag (set for anything but 2xx and 3xx).
// A parse error or a completed line returns the parser to the start of a new
// status line. A byte is first captured in an input register; in the next
// stage the parser state machine advances on it and the result is captured
// in an output register. Both stages move on together, so the block accepts
// one byte in every clock cycle while the sink keeps taking results. A result
// is offered on res_o once the output register has captured it; while it waits
// there, the parser holds and a full input register takes no new byte. The
// single sequential dependency is the parser state, updated once per byte.
// The alive mask (reset value 2xx and 3xx alive) is written through
// cfg_we_i and cfg_wdata_i and should only be changed while no bytes are in
// flight.
module http_status_line_health_check (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  hslhc_byte_if.sink                        rx_i,
  hslhc_result_if.source                    res_o,
  input  logic                              cfg_we_i,
  input  logic [hslhc_pkg::MaskW-1:0]       cfg_wdata_i
);

  // Input register stage.
  logic                               in_valid_q;
  logic [hslhc_pkg::ByteW-1:0]        in_byte_q;

  // Parser state.
  hslhc_pkg::parse_state_e            state_q;
  logic [hslhc_pkg::CodeW-1:0]        code_q;
  logic [hslhc_pkg::DigitW-1:0]       digits_q;
  logic [hslhc_pkg::MaskW-1:0]        mask_q;

  // Output register stage.
  logic                               out_valid_q;
  hslhc_pkg::step_t                   out_q;

  hslhc_pkg::step_t                   step;
  logic                               out_free;
  logic                               advance;

  // The output register can take a new result when it is empty or its word
  // leaves this cycle; the input register is then free to refill as well.
  assign out_free = !out_valid_q || res_o.ready;
  assign advance  = in_valid_q && out_free;
  assign rx_i.ready = !in_valid_q || out_free;

  hslhc_step u_step (
    .state_i  (state_q),
    .code_i   (code_q),
    .digits_i (digits_q),
    .byte_i   (in_byte_q),
    .mask_i   (mask_q),
    .step_o   (step)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= hslhc_pkg::PS_START;
      code_q   <= '0;
      digits_q <= '0;
    end else if (advance) begin
      state_q  <= step.next_state;
      code_q   <= step.next_code;
      digits_q <= step.next_digits;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= hslhc_pkg::MaskReset;
    end else if (cfg_we_i) begin
      mask_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= step;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.verdict     = out_q.verdict;
  assign res_o.status_code = out_q.status_code;
  assign res_o.code_class  = out_q.code_class;
  assign res_o.peer_error  = out_q.peer_error;

endmodule

### rtl/core/hslhc_step.sv
// One step of the status line parser: next state from the current state and
// one byte, and the result word. Purely combinational. Depends on hslhc_pkg.
module hslhc_step (
  input  hslhc_pkg::parse_state_e             state_i,
  input  logic [hslhc_pkg::CodeW-1:0]         code_i,
  input  logic [hslhc_pkg::DigitW-1:0]        digits_i,
  input  logic [hslhc_pkg::ByteW-1:0]         byte_i,
  input  logic [hslhc_pkg::MaskW-1:0]         mask_i,
  output hslhc_pkg::step_t                    step_o
);

  logic                            is_digit;
  logic [3:0]                      digit_val;
  logic [hslhc_pkg::CodeW-1:0]     code_acc;
  logic                            err;
  logic                            done;
  hslhc_pkg::parse_state_e         state_d;
  logic [hslhc_pkg::CodeW-1:0]     code_d;
  logic [hslhc_pkg::DigitW-1:0]    digits_d;
  logic [hslhc_pkg::ClassW-1:0]    cls;

  assign is_digit  = (byte_i >= hslhc_pkg::CH_ZERO) && (byte_i <= hslhc_pkg::CH_NINE);
  assign digit_val = byte_i[3:0];
  // Times ten as eight plus two, wrapping at ten bits.
  assign code_acc  = {code_i[6:0], 3'b000} + {code_i[8:0], 1'b0} + {6'b0, digit_val};

  // Next state.
  always_comb begin
    state_d  = state_i;
    code_d   = code_i;
    digits_d = digits_i;
    err      = 1'b0;
    done     = 1'b0;
    case (state_i)
      hslhc_pkg::PS_START: begin
        if (byte_i == hslhc_pkg::CH_H) state_d = hslhc_pkg::PS_H; else err = 1'b1;
      end
      hslhc_pkg::PS_H: begin
        if (byte_i == hslhc_pkg::CH_T) state_d = hslhc_pkg::PS_HT; else err = 1'b1;
      end
      hslhc_pkg::PS_HT: begin
        if (byte_i == hslhc_pkg::CH_T) state_d = hslhc_pkg::PS_HTT; else err = 1'b1;
      end
      hslhc_pkg::PS_HTT: begin
        if (byte_i == hslhc_pkg::CH_P) state_d = hslhc_pkg::PS_HTTP; else err = 1'b1;
      end
      hslhc_pkg::PS_HTTP: begin
        if (byte_i == hslhc_pkg::CH_SLASH) state_d = hslhc_pkg::PS_MAJ_FIRST;
        else err = 1'b1;
      end
      hslhc_pkg::PS_MAJ_FIRST: begin
        if (byte_i >= hslhc_pkg::CH_ONE && byte_i <= hslhc_pkg::CH_NINE) begin
          state_d = hslhc_pkg::PS_MAJ;
        end else begin
          err = 1'b1;
        end
      end
      hslhc_pkg::PS_MAJ: begin
        if (byte_i == hslhc_pkg::CH_DOT) state_d = hslhc_pkg::PS_MIN_FIRST;
        else if (!is_digit) err = 1'b1;
      end
      hslhc_pkg::PS_MIN_FIRST: begin
        if (is_digit) state_d = hslhc_pkg::PS_MIN; else err = 1'b1;
      end
      hslhc_pkg::PS_MIN: begin
        if (byte_i == hslhc_pkg::CH_SPACE) state_d = hslhc_pkg::PS_CODE;
        else if (!is_digit) err = 1'b1;
      end
      hslhc_pkg::PS_CODE: begin
        if (byte_i == hslhc_pkg::CH_SPACE) begin
          state_d = hslhc_pkg::PS_CODE;
        end else if (!is_digit) begin
          err = 1'b1;
        end else begin
          code_d = code_acc;
          if (digits_i >= 2'd2) begin
            digits_d = '0;
            state_d  = hslhc_pkg::PS_AFTER_CODE;
          end else begin
            digits_d = digits_i + 2'd1;
          end
        end
      end
      hslhc_pkg::PS_AFTER_CODE: begin
        if (byte_i == hslhc_pkg::CH_SPACE || byte_i == hslhc_pkg::CH_DOT) begin
          state_d = hslhc_pkg::PS_TEXT;
        end else if (byte_i == hslhc_pkg::CH_CR) begin
          state_d = hslhc_pkg::PS_LAST_LF;
        end else if (byte_i == hslhc_pkg::CH_LF) begin
          done = 1'b1;
        end else begin
          err = 1'b1;
        end
      end
      hslhc_pkg::PS_TEXT: begin
        if (byte_i == hslhc_pkg::CH_CR) state_d = hslhc_pkg::PS_WANT_LF;
        else if (byte_i == hslhc_pkg::CH_LF) done = 1'b1;
      end
      hslhc_pkg::PS_WANT_LF: begin
        if (byte_i == hslhc_pkg::CH_LF) state_d = hslhc_pkg::PS_WANT_CR; else err = 1'b1;
      end
      hslhc_pkg::PS_WANT_CR: begin
        state_d = (byte_i == hslhc_pkg::CH_CR) ? hslhc_pkg::PS_LAST_LF : hslhc_pkg::PS_TEXT;
      end
      hslhc_pkg::PS_LAST_LF: begin
        if (byte_i == hslhc_pkg::CH_LF) done = 1'b1; else err = 1'b1;
      end
      default: begin
        err = 1'b1;
      end
    endcase
    if (err || done) begin
      state_d  = hslhc_pkg::PS_START;
      code_d   = '0;
      digits_d = '0;
    end
  end

  assign cls = hslhc_pkg::class_of(code_i);

  // Result word.
  always_comb begin
    step_o.next_state  = state_d;
    step_o.next_code   = code_d;
    step_o.next_digits = digits_d;
    step_o.verdict     = hslhc_pkg::VERDICT_MORE;
    step_o.status_code = '0;
    step_o.code_class  = '0;
    step_o.peer_error  = 1'b0;
    if (err) begin
      step_o.verdict = hslhc_pkg::VERDICT_ERROR;
    end else if (done) begin
      step_o.verdict     = mask_i[cls] ? hslhc_pkg::VERDICT_ALIVE : hslhc_pkg::VERDICT_DEAD;
      step_o.status_code = code_i;
      step_o.code_class  = cls;
      step_o.peer_error  = (cls >= hslhc_pkg::CLASS_4XX);
    end
  end

endmodule
